@@ design/e2q_pkg.sv @@
// Shared constants, payload types and helpers for the Euler-to-quaternion converter.
package e2q_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int FRAC_BITS     = 14;
    localparam int CORDIC_STAGES = 16;

    // Q1.30 working format
    localparam int WORK_FRAC = 30;
    localparam int XY_W      = 32;              // CORDIC x/y (cos/sin), magnitude < 2^31
    localparam int Z_W       = 34;              // residual angle, 2^32 per turn
    localparam int M1_W      = 2 * XY_W;        // first product, full width
    localparam int P_W       = M1_W - WORK_FRAC; // first product back in Q1.30
    localparam int T_W       = P_W + XY_W;      // three-factor term, Q.60
    localparam int S_W       = T_W + 2;         // sum of two terms plus rounding headroom
    localparam int Q_W       = FRAC_BITS + 2;   // output component, Q1.FRAC_BITS
    localparam int ROUND_SH  = 2 * WORK_FRAC - FRAC_BITS;
    localparam int R_W       = S_W - ROUND_SH;  // rounded value before saturation

    // gain-corrected 1.0 in Q1.30
    localparam logic signed [XY_W-1:0] CORDIC_X0 = XY_W'(652032874);

    // atan(2^-i), 2^32 units per turn
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] roll_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] yaw_angle;
    } t_angles;

    typedef struct packed {
        logic signed [Q_W-1:0] quat_w;
        logic signed [Q_W-1:0] quat_x;
        logic signed [Q_W-1:0] quat_y;
        logic signed [Q_W-1:0] quat_z;
    } t_quat;

    // half of a binary angle, rescaled to 2^32 units per turn
    function automatic logic signed [Z_W-1:0] half_angle(
        input logic signed [ANGLE_BITS-1:0] a
    );
        logic signed [Z_W-1:0] ext;
        ext = Z_W'(a);
        if (ANGLE_BITS < 32)
            return ext <<< ((ANGLE_BITS < 32) ? (31 - ANGLE_BITS) : 0);
        else
            return ext >>> 1;
    endfunction

endpackage

@@ design/e2q_cordic.sv @@
// Pipelined rotation-mode CORDIC: one stage per register, yields cos and sin of the half angle.
module e2q_cordic (
    input  logic                                    i_clk,
    input  logic [e2q_pkg::CORDIC_STAGES-1:0]       i_en,
    input  logic signed [e2q_pkg::ANGLE_BITS-1:0]   i_angle,
    output logic signed [e2q_pkg::XY_W-1:0]         o_cos,
    output logic signed [e2q_pkg::XY_W-1:0]         o_sin
);

    logic signed [e2q_pkg::XY_W-1:0] r_x [e2q_pkg::CORDIC_STAGES];
    logic signed [e2q_pkg::XY_W-1:0] r_y [e2q_pkg::CORDIC_STAGES];
    logic signed [e2q_pkg::Z_W-1:0]  r_z [e2q_pkg::CORDIC_STAGES-1];

    for (genvar i = 0; i < e2q_pkg::CORDIC_STAGES; i++) begin : g_stage
        logic signed [e2q_pkg::XY_W-1:0] x_in, y_in, n_x, n_y;
        logic signed [e2q_pkg::Z_W-1:0]  z_in;

        if (i == 0) begin : g_first
            assign x_in = e2q_pkg::CORDIC_X0;
            assign y_in = '0;
            assign z_in = e2q_pkg::half_angle(i_angle);
        end else begin : g_next
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
            assign z_in = r_z[i-1];
        end

        // rotate towards zero residual
        always_comb begin
            if (z_in >= 0) begin
                n_x = x_in - (y_in >>> i);
                n_y = y_in + (x_in >>> i);
            end else begin
                n_x = x_in + (y_in >>> i);
                n_y = y_in - (x_in >>> i);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[i]) begin
                r_x[i] <= n_x;
                r_y[i] <= n_y;
            end
        end

        // residual angle is not needed after the last stage
        if (i < e2q_pkg::CORDIC_STAGES - 1) begin : g_z
            logic signed [e2q_pkg::Z_W-1:0] atan_i, n_z;
            assign atan_i = e2q_pkg::Z_W'(e2q_pkg::ATAN_TAB[i]);
            assign n_z    = (z_in >= 0) ? (z_in - atan_i) : (z_in + atan_i);

            always_ff @(posedge i_clk) begin
                if (i_en[i]) begin
                    r_z[i] <= n_z;
                end
            end
        end
    end

    assign o_cos = r_x[e2q_pkg::CORDIC_STAGES-1];
    assign o_sin = r_y[e2q_pkg::CORDIC_STAGES-1];

endmodule

@@ design/euler_to_quaternion.sv @@
// Top level: ZYX Euler angles (binary angle units) to saturated Q1.14 rotation quaternion.
// Pipeline: the CORDIC stages, two multiply stages and one round/saturate stage to the
//   output register; every stage is a register with its own valid bit.
// Throughput: one transaction per cycle while the output is not stalled.
// A stalled output holds only the stages that are full: bubbles further up still close.
// Reset (i_rst_n low, synchronous) clears all valid bits; o_ready is held low meanwhile.
module euler_to_quaternion (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  e2q_pkg::t_angles i_angles,
    output logic             o_valid,
    input  logic             i_ready,
    output e2q_pkg::t_quat   o_quat
);

    // stage map: CORDIC stages, first product, second product, output register
    localparam int ST_P1  = e2q_pkg::CORDIC_STAGES;
    localparam int ST_P2  = ST_P1 + 1;
    localparam int ST_OUT = ST_P2 + 1;
    localparam int DEPTH  = ST_OUT + 1;

    localparam logic signed [e2q_pkg::R_W-1:0] Q_ONE =
        e2q_pkg::R_W'(1) <<< e2q_pkg::FRAC_BITS;
    localparam logic signed [e2q_pkg::S_W-1:0] HALF_LSB =
        e2q_pkg::S_W'(1) <<< (e2q_pkg::ROUND_SH - 1);

    // ------------------------------------------------------------------
    // Flow control. A stage may load when it is empty or when some stage
    // further down is empty, or the output is being taken: the whole
    // chain below it is then able to move by one.
    // ------------------------------------------------------------------
    logic [DEPTH-1:0] r_vld, n_vld, en;

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            en[k] = i_ready || !(&(r_vld | ((DEPTH'(1) << k) - DEPTH'(1))));
        end
    end

    assign o_ready = en[0] && i_rst_n;

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            if (!en[k])
                n_vld[k] = r_vld[k];
            else if (k == 0)
                n_vld[k] = i_valid;
            else
                n_vld[k] = r_vld[(k == 0) ? 0 : k - 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // ------------------------------------------------------------------
    // Half-angle sine/cosine, three CORDIC pipelines in lock step
    // ------------------------------------------------------------------
    logic signed [e2q_pkg::XY_W-1:0] cr, sr, cp, sp, cy, sy;

    e2q_cordic u_cordic_roll (
        .i_clk   (i_clk),
        .i_en    (en[e2q_pkg::CORDIC_STAGES-1:0]),
        .i_angle (i_angles.roll_angle),
        .o_cos   (cr),
        .o_sin   (sr)
    );

    e2q_cordic u_cordic_pitch (
        .i_clk   (i_clk),
        .i_en    (en[e2q_pkg::CORDIC_STAGES-1:0]),
        .i_angle (i_angles.pitch_angle),
        .o_cos   (cp),
        .o_sin   (sp)
    );

    e2q_cordic u_cordic_yaw (
        .i_clk   (i_clk),
        .i_en    (en[e2q_pkg::CORDIC_STAGES-1:0]),
        .i_angle (i_angles.yaw_angle),
        .o_cos   (cy),
        .o_sin   (sy)
    );

    // ------------------------------------------------------------------
    // First products: roll x pitch, floored back to Q1.30.
    // Yaw terms ride along to line up with the second multiply.
    // ------------------------------------------------------------------
    logic signed [e2q_pkg::M1_W-1:0] m_cc, m_ss, m_sc, m_cs;
    logic signed [e2q_pkg::P_W-1:0]  r_cc, r_ss, r_sc, r_cs;
    logic signed [e2q_pkg::XY_W-1:0] r_cy, r_sy;

    assign m_cc = e2q_pkg::M1_W'(cr) * e2q_pkg::M1_W'(cp);
    assign m_ss = e2q_pkg::M1_W'(sr) * e2q_pkg::M1_W'(sp);
    assign m_sc = e2q_pkg::M1_W'(sr) * e2q_pkg::M1_W'(cp);
    assign m_cs = e2q_pkg::M1_W'(cr) * e2q_pkg::M1_W'(sp);

    always_ff @(posedge i_clk) begin
        if (en[ST_P1]) begin
            r_cc <= e2q_pkg::P_W'(m_cc >>> e2q_pkg::WORK_FRAC);
            r_ss <= e2q_pkg::P_W'(m_ss >>> e2q_pkg::WORK_FRAC);
            r_sc <= e2q_pkg::P_W'(m_sc >>> e2q_pkg::WORK_FRAC);
            r_cs <= e2q_pkg::P_W'(m_cs >>> e2q_pkg::WORK_FRAC);
            r_cy <= cy;
            r_sy <= sy;
        end
    end

    // ------------------------------------------------------------------
    // Second products: exact Q.60 terms, eight of them
    // ------------------------------------------------------------------
    logic signed [e2q_pkg::T_W-1:0] r_t_cc_cy, r_t_ss_sy, r_t_sc_cy, r_t_cs_sy;
    logic signed [e2q_pkg::T_W-1:0] r_t_cs_cy, r_t_sc_sy, r_t_cc_sy, r_t_ss_cy;

    always_ff @(posedge i_clk) begin
        if (en[ST_P2]) begin
            r_t_cc_cy <= e2q_pkg::T_W'(r_cc) * e2q_pkg::T_W'(r_cy);
            r_t_ss_sy <= e2q_pkg::T_W'(r_ss) * e2q_pkg::T_W'(r_sy);
            r_t_sc_cy <= e2q_pkg::T_W'(r_sc) * e2q_pkg::T_W'(r_cy);
            r_t_cs_sy <= e2q_pkg::T_W'(r_cs) * e2q_pkg::T_W'(r_sy);
            r_t_cs_cy <= e2q_pkg::T_W'(r_cs) * e2q_pkg::T_W'(r_cy);
            r_t_sc_sy <= e2q_pkg::T_W'(r_sc) * e2q_pkg::T_W'(r_sy);
            r_t_cc_sy <= e2q_pkg::T_W'(r_cc) * e2q_pkg::T_W'(r_sy);
            r_t_ss_cy <= e2q_pkg::T_W'(r_ss) * e2q_pkg::T_W'(r_cy);
        end
    end

    // ------------------------------------------------------------------
    // Combine, round half up to Q1.14, clamp to +/-1.0
    // ------------------------------------------------------------------
    function automatic logic signed [e2q_pkg::Q_W-1:0] round_sat(
        input logic signed [e2q_pkg::S_W-1:0] v
    );
        logic signed [e2q_pkg::S_W-1:0] rnd;
        logic signed [e2q_pkg::R_W-1:0] q;
        rnd = v + HALF_LSB;
        q   = e2q_pkg::R_W'(rnd >>> e2q_pkg::ROUND_SH);
        if (q > Q_ONE)
            q = Q_ONE;
        else if (q < -Q_ONE)
            q = -Q_ONE;
        return e2q_pkg::Q_W'(q);
    endfunction

    logic signed [e2q_pkg::S_W-1:0] sum_w, sum_x, sum_y, sum_z;
    e2q_pkg::t_quat                 r_quat;

    assign sum_w = e2q_pkg::S_W'(r_t_cc_cy) + e2q_pkg::S_W'(r_t_ss_sy);
    assign sum_x = e2q_pkg::S_W'(r_t_sc_cy) - e2q_pkg::S_W'(r_t_cs_sy);
    assign sum_y = e2q_pkg::S_W'(r_t_cs_cy) + e2q_pkg::S_W'(r_t_sc_sy);
    assign sum_z = e2q_pkg::S_W'(r_t_cc_sy) - e2q_pkg::S_W'(r_t_ss_cy);

    always_ff @(posedge i_clk) begin
        if (en[ST_OUT]) begin
            r_quat.quat_w <= round_sat(sum_w);
            r_quat.quat_x <= round_sat(sum_x);
            r_quat.quat_y <= round_sat(sum_y);
            r_quat.quat_z <= round_sat(sum_z);
        end
    end

    assign o_valid = r_vld[DEPTH-1];
    assign o_quat  = r_quat;

endmodule

@@ design/e2q_checker.sv @@
// Port-level checks for the Euler-to-quaternion converter, bound to its top level.
module e2q_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input e2q_pkg::t_quat   o_quat
);

    localparam logic signed [e2q_pkg::Q_W-1:0] Q_ONE =
        e2q_pkg::Q_W'(1) <<< e2q_pkg::FRAC_BITS;
    localparam logic signed [31:0] NORM_ONE = 32'sd1 <<< (2 * e2q_pkg::FRAC_BITS);
    localparam logic signed [31:0] NORM_TOL = 32'sd1 <<< (2 * e2q_pkg::FRAC_BITS - 8);

    logic signed [31:0] norm_sq;

    assign norm_sq = 32'(o_quat.quat_w) * 32'(o_quat.quat_w)
                   + 32'(o_quat.quat_x) * 32'(o_quat.quat_x)
                   + 32'(o_quat.quat_y) * 32'(o_quat.quat_y)
                   + 32'(o_quat.quat_z) * 32'(o_quat.quat_z);

    // nothing comes out straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_quat))
        else $error("stalled result dropped or changed");

    // an empty or draining output never blocks the input side
    a_no_needless_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("input stalled while pipeline can move");

    // components stay within plus or minus 1.0
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_quat.quat_w <= Q_ONE && o_quat.quat_w >= -Q_ONE
                 && o_quat.quat_x <= Q_ONE && o_quat.quat_x >= -Q_ONE
                 && o_quat.quat_y <= Q_ONE && o_quat.quat_y >= -Q_ONE
                 && o_quat.quat_z <= Q_ONE && o_quat.quat_z >= -Q_ONE)
        else $error("quaternion component out of range");

    // a rotation quaternion has unit norm, up to rounding
    a_unit_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> norm_sq >= NORM_ONE - NORM_TOL && norm_sq <= NORM_ONE + NORM_TOL)
        else $error("quaternion norm off unity");

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (.*);
